@@ src/sfe_pkg.sv @@
package sfe_pkg;

  localparam int unsigned DEF_FRAME_SAMPLES = 80;
  localparam int unsigned DEF_MAX_FRAMES    = 16;

  localparam int unsigned GAIN_SHIFT = 7;
  localparam int unsigned SAMPLE_W   = 32;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned DELAY_W    = 5;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 4;

  typedef enum logic [1:0] {
    REG_DELAY_FRAMES  = 2'd0,
    REG_FEEDBACK_GAIN = 2'd1,
    REG_OUTPUT_GAIN   = 2'd2
  } sfe_reg_e;

  typedef struct packed {
    logic [DELAY_W-1:0]       delay_frames;
    logic signed [GAIN_W-1:0] feedback_gain;
    logic signed [GAIN_W-1:0] output_gain;
    logic                     delay_wr;
  } sfe_cfg_t;

endpackage

@@ src/sfe_in_if.sv @@
interface sfe_in_if import sfe_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] in_left;
  logic signed [SAMPLE_W-1:0] in_right;

  modport source (output valid, output in_left, output in_right, input ready);
  modport sink (input valid, input in_left, input in_right, output ready);
endinterface

@@ src/sfe_out_if.sv @@
interface sfe_out_if import sfe_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] out_left;
  logic signed [SAMPLE_W-1:0] out_right;

  modport source (output valid, output out_left, output out_right, input ready);
  modport sink (input valid, input out_left, input out_right, output ready);
endinterface

@@ src/stereo_feedback_echo_unit.sv @@
// pipeline: an accepted word passes the B, C and O registers to the output
// throughput: one stereo word per cycle unless the output stalls; a new word
//   waits while an older word for the same ring slot is still in flight
//   (ring shorter than 3 slots); after a write of delay_frames, input waits
//   while the next frame index is recomputed by repeated subtraction
// reset: async active low; the ring reads as zero until each slot is written
module stereo_feedback_echo_unit import sfe_pkg::*; #(
  parameter int unsigned FRAME_SAMPLES = DEF_FRAME_SAMPLES,
  parameter int unsigned MAX_FRAMES    = DEF_MAX_FRAMES
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  sfe_in_if.sink                in_i,
  sfe_out_if.source             out_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned Depth = FRAME_SAMPLES * MAX_FRAMES;
  localparam int unsigned AddrW = Depth > 1 ? $clog2(Depth) : 1;

  sfe_cfg_t cfg;

  logic [AddrW-1:0]      pos;
  logic                  busy;
  logic                  accept;
  logic                  hazard;
  logic                  o_free, c_adv, c_free, b_adv, b_free;
  logic [2*SAMPLE_W-1:0] rd_data;

  logic                       b_valid_q;
  logic [AddrW-1:0]           b_pos_q;
  logic signed [SAMPLE_W-1:0] b_left_q, b_right_q;
  logic                       c_valid_q;
  logic [AddrW-1:0]           c_pos_q;
  logic                       o_valid_q;
  logic signed [SAMPLE_W-1:0] o_left_q, o_right_q;

  logic signed [SAMPLE_W-1:0] dly_l, dly_r;
  logic signed [SAMPLE_W-1:0] wr_l, wr_r;
  logic signed [SAMPLE_W-1:0] out_l, out_r;

  sfe_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sfe_seq #(
    .FRAME_SAMPLES (FRAME_SAMPLES),
    .MAX_FRAMES    (MAX_FRAMES),
    .ADDR_W        (AddrW)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .delay_frames_i (cfg.delay_frames),
    .delay_wr_i     (cfg.delay_wr),
    .step_i         (accept),
    .pos_o          (pos),
    .busy_o         (busy)
  );

  // stage flow: B holds the ring read, C the products, O the output word
  assign o_free = !o_valid_q || out_o.ready;
  assign c_adv  = c_valid_q && o_free;
  assign c_free = !c_valid_q || o_free;
  assign b_adv  = b_valid_q && c_free;
  assign b_free = !b_valid_q || c_free;

  // a slot still waiting for its write-back may not be read; a write at the
  // same edge as the read is forwarded by the ring
  assign hazard = (b_valid_q && (b_pos_q == pos)) ||
                  (c_valid_q && !c_adv && (c_pos_q == pos));

  assign in_i.ready = b_free && !hazard && !busy;
  assign accept     = in_i.valid && in_i.ready;

  sfe_ring #(
    .DEPTH  (Depth),
    .ADDR_W (AddrW)
  ) u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (pos),
    .wr_en_i   (c_adv),
    .wr_addr_i (c_pos_q),
    .wr_data_i ({wr_r, wr_l}),
    .rd_data_o (rd_data)
  );

  assign dly_l = rd_data[SAMPLE_W-1:0];
  assign dly_r = rd_data[2*SAMPLE_W-1:SAMPLE_W];

  sfe_lane u_lane_l (
    .clk_i      (clk_i),
    .en_i       (b_adv),
    .dly_i      (dly_l),
    .smp_i      (b_left_q),
    .fb_gain_i  (cfg.feedback_gain),
    .out_gain_i (cfg.output_gain),
    .wr_o       (wr_l),
    .out_o      (out_l)
  );

  sfe_lane u_lane_r (
    .clk_i      (clk_i),
    .en_i       (b_adv),
    .dly_i      (dly_r),
    .smp_i      (b_right_q),
    .fb_gain_i  (cfg.feedback_gain),
    .out_gain_i (cfg.output_gain),
    .wr_o       (wr_r),
    .out_o      (out_r)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (b_free) begin
        b_valid_q <= accept;
      end
      if (c_free) begin
        c_valid_q <= b_valid_q;
      end
      if (o_free) begin
        o_valid_q <= c_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_pos_q   <= pos;
      b_left_q  <= in_i.in_left;
      b_right_q <= in_i.in_right;
    end
    if (b_adv) begin
      c_pos_q <= b_pos_q;
    end
    if (c_adv) begin
      o_left_q  <= out_l;
      o_right_q <= out_r;
    end
  end

  assign out_o.valid     = o_valid_q;
  assign out_o.out_left  = o_left_q;
  assign out_o.out_right = o_right_q;

endmodule

@@ src/sfe_cfg.sv @@
module sfe_cfg import sfe_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output sfe_cfg_t              cfg_o
);

  logic [DELAY_W-1:0]       delay_q;
  logic signed [GAIN_W-1:0] fb_gain_q;
  logic signed [GAIN_W-1:0] out_gain_q;
  logic                     delay_wr_q;
  logic                     wr_en;
  sfe_reg_e                 reg_sel;

  assign reg_sel = sfe_reg_e'(paddr[APB_ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q    <= DELAY_W'(1);
      fb_gain_q  <= '0;
      out_gain_q <= '0;
      delay_wr_q <= 1'b0;
    end else begin
      delay_wr_q <= 1'b0;
      if (wr_en) begin
        case (reg_sel)
          REG_DELAY_FRAMES: begin
            delay_q    <= pwdata[DELAY_W-1:0];
            delay_wr_q <= 1'b1;
          end
          REG_FEEDBACK_GAIN: fb_gain_q <= pwdata[GAIN_W-1:0];
          REG_OUTPUT_GAIN:   out_gain_q <= pwdata[GAIN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    case (reg_sel)
      REG_DELAY_FRAMES:  prdata = APB_DATA_W'(delay_q);
      REG_FEEDBACK_GAIN: prdata = {{(APB_DATA_W-GAIN_W){fb_gain_q[GAIN_W-1]}}, fb_gain_q};
      REG_OUTPUT_GAIN:   prdata = {{(APB_DATA_W-GAIN_W){out_gain_q[GAIN_W-1]}}, out_gain_q};
      default:           prdata = '0;
    endcase
  end

  assign cfg_o.delay_frames  = delay_q;
  assign cfg_o.feedback_gain = fb_gain_q;
  assign cfg_o.output_gain   = out_gain_q;
  assign cfg_o.delay_wr      = delay_wr_q;

endmodule

@@ src/sfe_seq.sv @@
module sfe_seq import sfe_pkg::*; #(
  parameter int unsigned FRAME_SAMPLES = DEF_FRAME_SAMPLES,
  parameter int unsigned MAX_FRAMES    = DEF_MAX_FRAMES,
  parameter int unsigned ADDR_W        = $clog2(DEF_FRAME_SAMPLES * DEF_MAX_FRAMES)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [DELAY_W-1:0] delay_frames_i,
  input  logic               delay_wr_i,
  input  logic               step_i,
  output logic [ADDR_W-1:0]  pos_o,
  output logic               busy_o
);

  localparam int unsigned SmpW = FRAME_SAMPLES > 1 ? $clog2(FRAME_SAMPLES) : 1;
  localparam int unsigned FrmW = MAX_FRAMES > 1 ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned EffW = $clog2(MAX_FRAMES + 1);
  localparam int unsigned CmpW = EffW > DELAY_W ? EffW : DELAY_W;

  logic [SmpW-1:0]   smp_q, smp_d;
  logic [FrmW-1:0]   frm_q, frm_d;
  logic [FrmW-1:0]   nxt_q, nxt_d;
  logic [ADDR_W-1:0] base_q, base_d;
  logic [EffW-1:0]   mod_q, mod_d;
  logic              busy_q, busy_d;
  logic [CmpW-1:0]   dly_ext;
  logic [CmpW-1:0]   eff_ext;
  logic [EffW-1:0]   eff;
  logic              last_smp;

  // zero acts as one frame, large values clamp to the ring size
  assign dly_ext = CmpW'(delay_frames_i);
  assign eff_ext = (dly_ext == '0) ? CmpW'(1) :
                   (dly_ext > CmpW'(MAX_FRAMES)) ? CmpW'(MAX_FRAMES) : dly_ext;
  assign eff      = eff_ext[EffW-1:0];
  assign last_smp = (smp_q == SmpW'(FRAME_SAMPLES - 1));

  always_comb begin
    smp_d  = smp_q;
    frm_d  = frm_q;
    nxt_d  = nxt_q;
    base_d = base_q;
    mod_d  = mod_q;
    busy_d = busy_q;
    if (delay_wr_i) begin
      // new length: recompute the frame that follows the current one
      busy_d = 1'b1;
      mod_d  = EffW'(frm_q) + EffW'(1);
    end else if (busy_q) begin
      if (mod_q >= eff) begin
        mod_d = mod_q - eff;
      end else begin
        nxt_d  = mod_q[FrmW-1:0];
        busy_d = 1'b0;
      end
    end else if (step_i) begin
      if (last_smp) begin
        smp_d  = '0;
        frm_d  = nxt_q;
        base_d = ADDR_W'(nxt_q * FRAME_SAMPLES);
        nxt_d  = ((EffW'(nxt_q) + EffW'(1)) == eff) ? '0 : nxt_q + 1'b1;
      end else begin
        smp_d = smp_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_q  <= '0;
      frm_q  <= '0;
      nxt_q  <= '0;
      base_q <= '0;
      mod_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      smp_q  <= smp_d;
      frm_q  <= frm_d;
      nxt_q  <= nxt_d;
      base_q <= base_d;
      mod_q  <= mod_d;
      busy_q <= busy_d;
    end
  end

  assign pos_o  = base_q + ADDR_W'(smp_q);
  assign busy_o = busy_q || delay_wr_i;

endmodule

@@ src/sfe_ring.sv @@
module sfe_ring import sfe_pkg::*; #(
  parameter int unsigned DEPTH  = DEF_FRAME_SAMPLES * DEF_MAX_FRAMES,
  parameter int unsigned ADDR_W = $clog2(DEF_FRAME_SAMPLES * DEF_MAX_FRAMES)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  rd_en_i,
  input  logic [ADDR_W-1:0]     rd_addr_i,
  input  logic                  wr_en_i,
  input  logic [ADDR_W-1:0]     wr_addr_i,
  input  logic [2*SAMPLE_W-1:0] wr_data_i,
  output logic [2*SAMPLE_W-1:0] rd_data_o
);

  localparam int unsigned FillW = $clog2(DEPTH + 1);

  logic [2*SAMPLE_W-1:0] mem [DEPTH];
  logic [2*SAMPLE_W-1:0] mem_q;
  logic [2*SAMPLE_W-1:0] byp_data_q;
  logic                  byp_q;
  logic                  vld_q;
  logic [FillW-1:0]      fill_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      mem_q      <= mem[rd_addr_i];
      byp_data_q <= wr_data_i;
    end
  end

  // slots are first touched in address order, so everything below the fill
  // count has been written and everything above still reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q  <= 1'b0;
      vld_q  <= 1'b0;
      fill_q <= '0;
    end else if (rd_en_i) begin
      byp_q <= wr_en_i && (wr_addr_i == rd_addr_i);
      vld_q <= FillW'(rd_addr_i) < fill_q;
      if (FillW'(rd_addr_i) == fill_q) begin
        fill_q <= fill_q + 1'b1;
      end
    end
  end

  assign rd_data_o = byp_q ? byp_data_q : (vld_q ? mem_q : '0);

endmodule

@@ src/sfe_lane.sv @@
module sfe_lane import sfe_pkg::*; (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic signed [SAMPLE_W-1:0] dly_i,
  input  logic signed [SAMPLE_W-1:0] smp_i,
  input  logic signed [GAIN_W-1:0]   fb_gain_i,
  input  logic signed [GAIN_W-1:0]   out_gain_i,
  output logic signed [SAMPLE_W-1:0] wr_o,
  output logic signed [SAMPLE_W-1:0] out_o
);

  localparam int unsigned ProdW = SAMPLE_W + GAIN_W;
  localparam int unsigned KeepW = SAMPLE_W - GAIN_SHIFT;

  logic signed [ProdW-1:0]    fb_prod;
  logic signed [ProdW-1:0]    out_prod;
  logic [KeepW-1:0]           fb_q;
  logic [KeepW-1:0]           out_q;
  logic signed [SAMPLE_W-1:0] smp_q;

  assign fb_prod  = dly_i * fb_gain_i;
  assign out_prod = dly_i * out_gain_i;

  // only the low word of the product counts, then the arithmetic shift
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fb_q  <= fb_prod[SAMPLE_W-1:GAIN_SHIFT];
      out_q <= out_prod[SAMPLE_W-1:GAIN_SHIFT];
      smp_q <= smp_i;
    end
  end

  assign wr_o  = smp_q + {{GAIN_SHIFT{fb_q[KeepW-1]}}, fb_q};
  assign out_o = {{GAIN_SHIFT{out_q[KeepW-1]}}, out_q};

endmodule

@@ src/sfe_checker.sv @@
module sfe_checker import sfe_pkg::*; (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic signed [SAMPLE_W-1:0] out_left_i,
  input logic signed [SAMPLE_W-1:0] out_right_i
);

  logic       in_acc;
  logic       out_acc;
  logic [2:0] cnt_q;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // words accepted and not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + 3'(in_acc) - 3'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_left_i) && $stable(out_right_i))
    else $error("output word changed while stalled");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> cnt_q != 3'd0)
    else $error("output word with nothing in flight");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && cnt_q == 3'd3 |-> out_acc)
    else $error("more than three words in flight");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc ##1 out_ready_i ##1 out_ready_i |=> out_valid_i)
    else $error("word did not reach the output in three cycles");

endmodule

bind stereo_feedback_echo_unit sfe_checker u_sfe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_left_i  (out_o.out_left),
  .out_right_i (out_o.out_right)
);

@@ verif/testbench.sv @@
module testbench;
  import sfe_pkg::*;

  localparam int unsigned RING_DEPTH  = DEF_MAX_FRAMES * DEF_FRAME_SAMPLES;
  localparam int unsigned SPARE_REG   = 3;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned QUIET_LIMIT = 5000;
  localparam int unsigned NUM_PHASES  = 7;

  typedef struct packed {
    logic [SAMPLE_W-1:0] l;
    logic [SAMPLE_W-1:0] r;
  } stereo_t;

  class echo_scoreboard;
    logic [SAMPLE_W-1:0]      ring_l [RING_DEPTH];
    logic [SAMPLE_W-1:0]      ring_r [RING_DEPTH];
    int unsigned              frame_pos;
    int unsigned              sample_pos;
    logic [DELAY_W-1:0]       frames_cfg;
    logic signed [GAIN_W-1:0] fb_gain;
    logic signed [GAIN_W-1:0] out_gain;
    stereo_t                  echo_due [$];
    int                       errors;

    function new();
      foreach (ring_l[i]) begin
        ring_l[i] = '0;
        ring_r[i] = '0;
      end
      frame_pos  = 0;
      sample_pos = 0;
      frames_cfg = DELAY_W'(1);
      fb_gain    = '0;
      out_gain   = '0;
      errors     = 0;
    endfunction

    function void write_reg(int unsigned idx, logic [APB_DATA_W-1:0] value);
      case (idx)
        REG_DELAY_FRAMES:  frames_cfg = value[DELAY_W-1:0];
        REG_FEEDBACK_GAIN: fb_gain = value[GAIN_W-1:0];
        REG_OUTPUT_GAIN:   out_gain = value[GAIN_W-1:0];
        default: ;
      endcase
    endfunction

    // wrapped 32-bit product, arithmetic shift down to unity gain
    function logic signed [SAMPLE_W-1:0] apply_gain(logic signed [SAMPLE_W-1:0] s,
                                                    logic signed [GAIN_W-1:0] g);
      logic signed [SAMPLE_W-1:0] g_ext;
      logic signed [SAMPLE_W-1:0] prod;
      g_ext = SAMPLE_W'(g);
      prod  = s * g_ext;
      return prod >>> GAIN_SHIFT;
    endfunction

    function void absorb_sample(logic [SAMPLE_W-1:0] l, logic [SAMPLE_W-1:0] r);
      int unsigned         slot;
      int unsigned         span;
      logic [SAMPLE_W-1:0] dl;
      logic [SAMPLE_W-1:0] dr;
      stereo_t             due;
      slot = frame_pos * DEF_FRAME_SAMPLES + sample_pos;
      dl = ring_l[slot];
      dr = ring_r[slot];
      ring_l[slot] = l + apply_gain(dl, fb_gain);
      ring_r[slot] = r + apply_gain(dr, fb_gain);
      due.l = apply_gain(dl, out_gain);
      due.r = apply_gain(dr, out_gain);
      echo_due.push_back(due);
      sample_pos++;
      if (sample_pos == DEF_FRAME_SAMPLES) begin
        sample_pos = 0;
        // new delay length only bites here, zero acts as one frame
        if (frames_cfg == 0) span = 1;
        else if (frames_cfg > DEF_MAX_FRAMES) span = DEF_MAX_FRAMES;
        else span = frames_cfg;
        frame_pos = (frame_pos + 1) % span;
      end
    endfunction

    function void compare_output(logic [SAMPLE_W-1:0] l, logic [SAMPLE_W-1:0] r);
      stereo_t due;
      if (echo_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected output word %h %h", l, r);
      end else begin
        due = echo_due.pop_front();
        if (due.l !== l || due.r !== r) begin
          errors++;
          if (errors <= 10)
            $display("output mismatch: expected %h %h, got %h %h", due.l, due.r, l, r);
        end
      end
    endfunction

    function int pending();
      return echo_due.size();
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  sfe_in_if  in_ch ();
  sfe_out_if out_ch ();

  echo_scoreboard sb = new();

  bit tx_idle_on  = 1'b1;
  bit rx_idle_on  = 1'b1;
  bit rx_hold_req = 1'b0;
  int rx_wait     = 0;

  stereo_feedback_echo_unit uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk_i = ~clk_i;

  // output side: check accepted words, then pick next ready
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready)
      sb.compare_output(out_ch.out_left, out_ch.out_right);
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (rx_hold_req) begin
        rx_wait = LONG_HOLD;
        rx_hold_req = 1'b0;
      end
      if (rx_wait > 0) begin
        rx_wait--;
        out_ch.ready <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
        rx_wait = $urandom_range(0, 5);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("testbench failed");
    $finish;
  end

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    logic [SAMPLE_W-1:0] v;
    v = $urandom;
    case ($urandom_range(0, 9))
      0: v = 32'h7fff_ffff;
      1: v = 32'h8000_0000;
      2: v = '0;
      3: v = {{24{v[7]}}, v[7:0]};
      default: ;
    endcase
    return v;
  endfunction

  task automatic send_word(input logic [SAMPLE_W-1:0] l, input logic [SAMPLE_W-1:0] r);
    if (tx_idle_on && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.in_left  <= l;
    in_ch.in_right <= r;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sb.absorb_sample(l, r);
  endtask

  task automatic reg_write(input int unsigned idx, input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(idx << 2);
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_reg(idx, data);
    @(posedge clk_i);
  endtask

  // stop offering words and let the pipeline empty
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_echo(input logic [DELAY_W-1:0] frames,
                          input logic [GAIN_W-1:0] fb, input logic [GAIN_W-1:0] og);
    logic [APB_DATA_W-1:0] word;
    settle();
    // upper bits are junk the block must drop
    word = $urandom;
    word[DELAY_W-1:0] = frames;
    reg_write(REG_DELAY_FRAMES, word);
    word = $urandom;
    word[GAIN_W-1:0] = fb;
    reg_write(REG_FEEDBACK_GAIN, word);
    word = $urandom;
    word[GAIN_W-1:0] = og;
    reg_write(REG_OUTPUT_GAIN, word);
    if ($urandom_range(0, 1) == 0) reg_write(SPARE_REG, $urandom);
  endtask

  initial begin
    logic [SAMPLE_W-1:0] edge_vals [8];
    int                  phase_frames [NUM_PHASES];
    int                  phase_fb [NUM_PHASES];
    int                  phase_og [NUM_PHASES];
    int                  phase_len [NUM_PHASES];
    logic [GAIN_W-1:0]   fb;
    logic [GAIN_W-1:0]   og;

    edge_vals = '{32'h0, 32'h1, 32'hffff_ffff, 32'h7fff_ffff,
                  32'h8000_0000, 32'h5555_5555, 32'haaaa_aaaa, 32'h0000_ffff};
    phase_frames = '{0, 31, 2, 16, 1, 3, 17};
    phase_fb     = '{128, -32768, 32767, 0, 64, 0, -128};
    phase_og     = '{128, 32767, -32768, 0, 128, 0, 32767};
    phase_len    = '{220, 180, 260, 200, 260, 280, 250};

    rst_ni         <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.in_left  <= '0;
    in_ch.in_right <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // extremes under reset settings; the ring holds one frame and both gains are zero
    for (int i = 0; i < 24; i++)
      send_word(edge_vals[i % 8], edge_vals[(i * 3 + 1) % 8]);
    settle();
    reg_write(SPARE_REG, 32'hffff_ffff);

    for (int p = 0; p < NUM_PHASES; p++) begin
      fb = GAIN_W'(phase_fb[p]);
      og = GAIN_W'(phase_og[p]);
      if (p == 3 || p == 5) begin
        fb = GAIN_W'($urandom);
        og = GAIN_W'($urandom);
      end
      set_echo(DELAY_W'(phase_frames[p]), fb, og);
      if (p == 2) rx_hold_req = 1'b1;
      if (p == NUM_PHASES - 1) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end
      for (int i = 0; i < phase_len[p]; i++)
        send_word(pick_sample(), pick_sample());
    end

    settle();
    repeat (10) @(posedge clk_i);
    if (sb.pending() != 0) $display("%0d output words never arrived", sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

@@ stereo_feedback_echo_unit.f @@
src/sfe_pkg.sv
src/sfe_in_if.sv
src/sfe_out_if.sv
src/sfe_cfg.sv
src/sfe_seq.sv
src/sfe_ring.sv
src/sfe_lane.sv
src/stereo_feedback_echo_unit.sv
src/sfe_checker.sv
verif/testbench.sv
